// File: hdl/lavm_pkg.sv
// Shared payload types and constants for the look-at view matrix core.
package lavm_pkg;

    // One camera beat: eye point, target point and up hint, signed Q.F.
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
    } camera_t;

    // One matrix beat: a group of four values of the view matrix.
    typedef struct packed {
        logic        [1:0]  group_index;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
        logic               degenerate;
        logic               last_group;
    } matrix_t;

    // Index of the translation group, sent last.
    localparam logic [1:0] LAST_GROUP = 2'd3;

endpackage

// File: hdl/lavm_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface lavm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/lavm_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
module lavm_norm #(
    parameter int W  = 33,
    parameter int F  = 16,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [SW-1:0]        side_in,
    input  logic [2:0][W-1:0]    vec,
    output logic                 vld_out,
    output logic [SW-1:0]        side_out,
    output logic [2:0][F+1:0]    unit,
    output logic                 zero
);
    localparam int MW  = 30;            // scaled magnitude width, top in [2^29, 2^30)
    localparam int TOP = MW - 1;
    localparam int PSW = $clog2(W);
    localparam int XW  = 2 * MW + 2;    // sum of three squares
    localparam int RS  = MW + 1;        // root steps, first trial bit 4^(RS-1)
    localparam int LW  = MW + 1;        // root width
    localparam int DV  = F + MW + 1;    // dividend width
    localparam int QW  = F + 1;         // quotient width
    localparam int DS  = F + 1;         // divide steps
    localparam int TW  = SW + 4;        // {side, zero, neg[2:0]}

    // stage 1: magnitudes
    logic              s1_vld_reg;
    logic [2:0][W-1:0] s1_mag_reg;
    logic [2:0]        s1_neg_reg;
    logic [SW-1:0]     s1_side_reg;
    // stage 2: leading one
    logic              s2_vld_reg;
    logic [2:0][W-1:0] s2_mag_reg;
    logic [PSW-1:0]    s2_pos_reg, s2_pos_next;
    logic              s2_zero_reg;
    logic [2:0]        s2_neg_reg;
    logic [SW-1:0]     s2_side_reg;
    // stage 3: scaled
    logic               s3_vld_reg;
    logic [2:0][MW-1:0] s3_m_reg, s3_m_next;
    logic [TW-1:0]      s3_tag_reg;
    // stage 4: squares
    logic                 s4_vld_reg;
    logic [2:0][MW-1:0]   s4_m_reg;
    logic [2:0][2*MW-1:0] s4_sq_reg;
    logic [TW-1:0]        s4_tag_reg;
    // root pipeline, index 0 holds the sum
    logic               rv_reg [RS+1];
    logic [XW-1:0]      rx_reg [RS+1];
    logic [XW-1:0]      rx_next [RS+1];
    logic [XW-1:0]      rr_reg [RS+1];
    logic [XW-1:0]      rr_next [RS+1];
    logic [2:0][MW-1:0] rm_reg [RS+1];
    logic [TW-1:0]      rt_reg [RS+1];
    // divide pipeline, index 0 holds the rounded dividends
    logic               dv_reg [DS+1];
    logic [2:0][DV-1:0] drem_reg [DS+1];
    logic [2:0][DV-1:0] drem_next [DS+1];
    logic [2:0][QW-1:0] dq_reg [DS+1];
    logic [2:0][QW-1:0] dq_next [DS+1];
    logic [LW-1:0]      dlen_reg [DS+1];
    logic [TW-1:0]      dt_reg [DS+1];
    // output
    logic               o_vld_reg;
    logic [2:0][F+1:0]  o_unit_reg, o_unit_next;
    logic               o_zero_reg;
    logic [SW-1:0]      o_side_reg;

    logic [W-1:0] or_mag;

    always_comb
    begin
        or_mag = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        s2_pos_next = '0;
        for (int i = 0; i < W; i++)
        begin
            if (or_mag[i])
            begin
                s2_pos_next = PSW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s2_pos_reg > PSW'(TOP))
            begin
                s3_m_next[i] = MW'(s2_mag_reg[i] >> (s2_pos_reg - PSW'(TOP)));
            end
            else
            begin
                s3_m_next[i] = MW'(s2_mag_reg[i] << (PSW'(TOP) - s2_pos_reg));
            end
        end
    end

    // one trial bit per stage of the digit-by-digit square root
    always_comb
    begin
        rx_next[0] = '0;
        rr_next[0] = '0;
        for (int k = 1; k <= RS; k++)
        begin
            logic [XW-1:0] bitv;
            logic [XW-1:0] trial;
            bitv  = XW'(1) << (2 * (RS - k));
            trial = rr_reg[k-1] + bitv;
            if (rx_reg[k-1] >= trial)
            begin
                rx_next[k] = rx_reg[k-1] - trial;
                rr_next[k] = (rr_reg[k-1] >> 1) + bitv;
            end
            else
            begin
                rx_next[k] = rx_reg[k-1];
                rr_next[k] = rr_reg[k-1] >> 1;
            end
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb
    begin
        drem_next[0] = '0;
        dq_next[0]   = '0;
        for (int k = 1; k <= DS; k++)
        begin
            logic [DV-1:0] dsh;
            dsh = DV'(dlen_reg[k-1]) << (DS - k);
            for (int i = 0; i < 3; i++)
            begin
                if (drem_reg[k-1][i] >= dsh)
                begin
                    drem_next[k][i] = drem_reg[k-1][i] - dsh;
                    dq_next[k][i]   = {dq_reg[k-1][i][QW-2:0], 1'b1};
                end
                else
                begin
                    drem_next[k][i] = drem_reg[k-1][i];
                    dq_next[k][i]   = {dq_reg[k-1][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dt_reg[DS][3])
            begin
                o_unit_next[i] = '0;
            end
            else if (dt_reg[DS][i])
            begin
                o_unit_next[i] = -((F+2)'(dq_reg[DS][i]));
            end
            else
            begin
                o_unit_next[i] = (F+2)'(dq_reg[DS][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            for (int k = 0; k <= RS; k++)
            begin
                rv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            rv_reg[0]  <= s4_vld_reg;
            for (int k = 1; k <= RS; k++)
            begin
                rv_reg[k] <= rv_reg[k-1];
            end
            dv_reg[0] <= rv_reg[RS];
            for (int k = 1; k <= DS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            o_vld_reg <= dv_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_neg_reg[i] <= vec[i][W-1];
                s1_mag_reg[i] <= vec[i][W-1] ? (~vec[i] + W'(1)) : vec[i];
                s4_sq_reg[i]  <= s3_m_reg[i] * s3_m_reg[i];
            end
            s1_side_reg <= side_in;

            s2_mag_reg  <= s1_mag_reg;
            s2_pos_reg  <= s2_pos_next;
            s2_zero_reg <= (or_mag == '0);
            s2_neg_reg  <= s1_neg_reg;
            s2_side_reg <= s1_side_reg;

            s3_m_reg   <= s3_m_next;
            s3_tag_reg <= {s2_side_reg, s2_zero_reg, s2_neg_reg};

            s4_m_reg   <= s3_m_reg;
            s4_tag_reg <= s3_tag_reg;

            rx_reg[0] <= XW'(s4_sq_reg[0]) + XW'(s4_sq_reg[1]) + XW'(s4_sq_reg[2]);
            rr_reg[0] <= '0;
            rm_reg[0] <= s4_m_reg;
            rt_reg[0] <= s4_tag_reg;
            for (int k = 1; k <= RS; k++)
            begin
                rx_reg[k] <= rx_next[k];
                rr_reg[k] <= rr_next[k];
                rm_reg[k] <= rm_reg[k-1];
                rt_reg[k] <= rt_reg[k-1];
            end

            // dividend carries half the root so the quotient rounds to nearest
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= (DV'(rm_reg[RS][i]) << F) + DV'(rr_reg[RS][LW-1:1]);
            end
            dq_reg[0]   <= '0;
            dlen_reg[0] <= rr_reg[RS][LW-1:0];
            dt_reg[0]   <= rt_reg[RS];
            for (int k = 1; k <= DS; k++)
            begin
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
                dlen_reg[k] <= dlen_reg[k-1];
                dt_reg[k]   <= dt_reg[k-1];
            end

            o_unit_reg <= o_unit_next;
            o_zero_reg <= dt_reg[DS][3];
            o_side_reg <= dt_reg[DS][TW-1:4];
        end
    end

    assign vld_out  = o_vld_reg;
    assign side_out = o_side_reg;
    assign unit     = o_unit_reg;
    assign zero     = o_zero_reg;

endmodule

// File: hdl/lavm_cross.sv
// Two-stage exact cross product of two signed 3-vectors.
module lavm_cross #(
    parameter int AW = 32,
    parameter int BW = 18,
    parameter int SW = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [SW-1:0]         side_in,
    input  logic [2:0][AW-1:0]    a,
    input  logic [2:0][BW-1:0]    b,
    output logic                  vld_out,
    output logic [SW-1:0]         side_out,
    output logic [2:0][AW+BW:0]   prod
);
    localparam int PW = AW + BW;
    localparam int RW = PW + 1;

    logic              p_vld_reg;
    logic [5:0][PW-1:0] p_reg;
    logic [SW-1:0]     p_side_reg;
    logic              r_vld_reg;
    logic [2:0][RW-1:0] r_reg;
    logic [SW-1:0]     r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= vld_in;
            r_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= $signed(a[1]) * $signed(b[2]);
            p_reg[1] <= $signed(a[2]) * $signed(b[1]);
            p_reg[2] <= $signed(a[2]) * $signed(b[0]);
            p_reg[3] <= $signed(a[0]) * $signed(b[2]);
            p_reg[4] <= $signed(a[0]) * $signed(b[1]);
            p_reg[5] <= $signed(a[1]) * $signed(b[0]);
            p_side_reg <= side_in;

            r_reg[0] <= RW'($signed(p_reg[0])) - RW'($signed(p_reg[1]));
            r_reg[1] <= RW'($signed(p_reg[2])) - RW'($signed(p_reg[3]));
            r_reg[2] <= RW'($signed(p_reg[4])) - RW'($signed(p_reg[5]));
            r_side_reg <= p_side_reg;
        end
    end

    assign vld_out  = r_vld_reg;
    assign side_out = r_side_reg;
    assign prod     = r_reg;

endmodule

// File: hdl/lavm_dot.sv
// Four-stage negated dot products of three axes with the eye, rounded and saturated.
module lavm_dot #(
    parameter int AW = 19,
    parameter int F  = 16,
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_in,
    input  logic [SW-1:0]           side_in,
    input  logic [2:0][2:0][AW-1:0] axis,
    input  logic [2:0][31:0]        eye,
    output logic                    vld_out,
    output logic [SW-1:0]           side_out,
    output logic [2:0][31:0]        trans
);
    localparam int PW  = AW + 32;
    localparam int SMW = PW + 2;

    logic                    p_vld_reg, s_vld_reg, m_vld_reg, t_vld_reg;
    logic [2:0][2:0][PW-1:0] p_reg;
    logic [2:0][SMW-1:0]     s_reg;
    logic [2:0][SMW-1:0]     m_reg;
    logic [2:0]              m_neg_reg;
    logic [2:0][31:0]        t_reg, t_next;
    logic [SW-1:0]           p_side_reg, s_side_reg, m_side_reg, t_side_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic [SMW-1:0] rm;
            rm = (m_reg[j] + (SMW'(1) << (F - 1))) >> F;
            if (m_neg_reg[j])
            begin
                t_next[j] = (rm > SMW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-rm);
            end
            else
            begin
                t_next[j] = (rm > SMW'(64'h7fff_ffff)) ? 32'h7fff_ffff : 32'(rm);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= vld_in;
            s_vld_reg <= p_vld_reg;
            m_vld_reg <= s_vld_reg;
            t_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[j][i] <= $signed(axis[j][i]) * $signed(eye[i]);
                end
                s_reg[j] <= SMW'($signed(p_reg[j][0])) + SMW'($signed(p_reg[j][1]))
                          + SMW'($signed(p_reg[j][2]));
                // negating the sum: result is negative when the sum is positive
                m_neg_reg[j] <= !s_reg[j][SMW-1] && (s_reg[j] != '0);
                m_reg[j]     <= s_reg[j][SMW-1] ? -s_reg[j] : s_reg[j];
            end
            t_reg      <= t_next;
            p_side_reg <= side_in;
            s_side_reg <= p_side_reg;
            m_side_reg <= s_side_reg;
            t_side_reg <= m_side_reg;
        end
    end

    assign vld_out  = t_vld_reg;
    assign side_out = t_side_reg;
    assign trans    = t_reg;

endmodule

// File: hdl/look_at_view_matrix_core.sv
// Top level: left-handed look-at view matrix, fully pipelined, four beats out per camera.
//
//  channel   dir  beat                                  payload
//  --------  ---  ------------------------------------  ---------------------------
//  camera    in   one eye/target/up set, Q16.16          lavm_pkg::camera_t
//  matrix    out  one group of four matrix values        lavm_pkg::matrix_t
//
//  Each camera beat yields four matrix beats (groups 0..3, last_group on 3).
//  Most of the path from camera to first group, for Q16.16 as for any FRACTION_BITS,
//  lies in the two normalizers (root: 31 stages, divide: FRACTION_BITS+1).
//  The single matrix port, sending four groups per camera, sets the sustained rate.
//  The pipeline advances on one global enable, holding whole only while a finished matrix
//  waits on the sending output group register: back-pressure drops or repeats nothing.
//  rst_n clears all valid bits and the output sequencer; data regs are not reset.
module look_at_view_matrix_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lavm_stream_if.sink          camera,
    lavm_stream_if.source        matrix
);
    localparam int F    = FRACTION_BITS;
    localparam int FW   = F + 2;             // unit axis width, |x| <= 2^F
    localparam int UW   = F + 3;             // camera up axis width
    localparam int C1W  = 32 + FW + 1;       // up x forward
    localparam int C2W  = 2 * FW + 1;        // forward x side
    localparam int N1SW = 192;
    localparam int C1SW = 96 + 3 * FW + 1;
    localparam int C2SW = 96 + 6 * FW + 1;
    localparam int DTSW = 3 * 96 + 1;

    // global advance
    logic en;
    logic ser_free;
    logic load;

    // entry stage: target - eye
    logic              e_vld_reg;
    logic [2:0][32:0]  e_dir_reg;
    logic [2:0][31:0]  e_eye_reg;
    logic [2:0][31:0]  e_up_reg;

    // forward normalizer
    logic              n1_vld;
    logic [N1SW-1:0]   n1_side;
    logic [2:0][FW-1:0] n1_f;
    logic              n1_zero;
    logic [2:0][31:0]  n1_eye, n1_up;

    // up x forward
    logic               c1_vld;
    logic [C1SW-1:0]    c1_side;
    logic [2:0][C1W-1:0] c1_prod;

    // side normalizer
    logic               n2_vld;
    logic [C1SW-1:0]    n2_side;
    logic [2:0][FW-1:0] n2_s;
    logic               n2_zero;
    logic [2:0][31:0]   n2_eye;
    logic [2:0][FW-1:0] n2_f;
    logic               n2_deg;

    // forward x side
    logic               c2_vld;
    logic [C2SW-1:0]    c2_side;
    logic [2:0][C2W-1:0] c2_prod;
    logic [2:0][31:0]   c2_eye;
    logic [2:0][FW-1:0] c2_f, c2_s;
    logic               c2_deg;

    // rounding stage for the camera up axis
    logic               r_vld_reg;
    logic [2:0][UW-1:0] r_u_reg, r_u_next;
    logic [2:0][31:0]   r_eye_reg;
    logic [2:0][FW-1:0] r_f_reg, r_s_reg;
    logic               r_deg_reg;

    // translation
    logic [2:0][2:0][UW-1:0] axis;
    logic [2:0][31:0]        f32, u32, s32;
    logic                    dt_vld;
    logic [DTSW-1:0]         dt_side;
    logic [2:0][31:0]        dt_trans;
    logic [2:0][31:0]        dt_f, dt_u, dt_s;
    logic                    dt_deg;

    // output group sequencer
    logic              busy_reg, busy_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [2:0][31:0]  m_s_reg, m_u_reg, m_f_reg, m_t_reg;
    logic              m_deg_reg;

    assign ser_free     = !busy_reg || (matrix.ready && (cnt_reg == lavm_pkg::LAST_GROUP));
    assign en           = !dt_vld || ser_free;
    assign load         = dt_vld && ser_free;
    assign camera.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= camera.valid;
            r_vld_reg <= c2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_dir_reg[0] <= 33'(camera.payload.target_x) - 33'(camera.payload.eye_x);
            e_dir_reg[1] <= 33'(camera.payload.target_y) - 33'(camera.payload.eye_y);
            e_dir_reg[2] <= 33'(camera.payload.target_z) - 33'(camera.payload.eye_z);
            e_eye_reg    <= {camera.payload.eye_z, camera.payload.eye_y,
                             camera.payload.eye_x};
            e_up_reg     <= {camera.payload.upward_z, camera.payload.upward_y,
                             camera.payload.upward_x};
        end
    end

    lavm_norm #(
        .W  (33),
        .F  (F),
        .SW (N1SW)
    ) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (e_vld_reg),
        .side_in  ({e_eye_reg, e_up_reg}),
        .vec      (e_dir_reg),
        .vld_out  (n1_vld),
        .side_out (n1_side),
        .unit     (n1_f),
        .zero     (n1_zero)
    );

    assign {n1_eye, n1_up} = n1_side;

    lavm_cross #(
        .AW (32),
        .BW (FW),
        .SW (C1SW)
    ) u_cross_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (n1_vld),
        .side_in  ({n1_eye, n1_f, n1_zero}),
        .a        (n1_up),
        .b        (n1_f),
        .vld_out  (c1_vld),
        .side_out (c1_side),
        .prod     (c1_prod)
    );

    lavm_norm #(
        .W  (C1W),
        .F  (F),
        .SW (C1SW)
    ) u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (c1_vld),
        .side_in  (c1_side),
        .vec      (c1_prod),
        .vld_out  (n2_vld),
        .side_out (n2_side),
        .unit     (n2_s),
        .zero     (n2_zero)
    );

    assign {n2_eye, n2_f, n2_deg} = n2_side;

    lavm_cross #(
        .AW (FW),
        .BW (FW),
        .SW (C2SW)
    ) u_cross_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (n2_vld),
        .side_in  ({n2_eye, n2_f, n2_s, n2_deg | n2_zero}),
        .a        (n2_f),
        .b        (n2_s),
        .vld_out  (c2_vld),
        .side_out (c2_side),
        .prod     (c2_prod)
    );

    assign {c2_eye, c2_f, c2_s, c2_deg} = c2_side;

    // camera up = (f x s) >> F, rounding half away from zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [C2W-1:0] cm;
            logic [C2W-1:0] cr;
            cm = c2_prod[i][C2W-1] ? -c2_prod[i] : c2_prod[i];
            cr = (cm + (C2W'(1) << (F - 1))) >> F;
            r_u_next[i] = c2_prod[i][C2W-1] ? UW'(-cr) : UW'(cr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_u_reg   <= r_u_next;
            r_eye_reg <= c2_eye;
            r_f_reg   <= c2_f;
            r_s_reg   <= c2_s;
            r_deg_reg <= c2_deg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            axis[0][i] = UW'($signed(r_s_reg[i]));
            axis[1][i] = r_u_reg[i];
            axis[2][i] = UW'($signed(r_f_reg[i]));
            s32[i]     = 32'($signed(r_s_reg[i]));
            u32[i]     = 32'($signed(r_u_reg[i]));
            f32[i]     = 32'($signed(r_f_reg[i]));
        end
    end

    lavm_dot #(
        .AW (UW),
        .F  (F),
        .SW (DTSW)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (r_vld_reg),
        .side_in  ({f32, u32, s32, r_deg_reg}),
        .axis     (axis),
        .eye      (r_eye_reg),
        .vld_out  (dt_vld),
        .side_out (dt_side),
        .trans    (dt_trans)
    );

    assign {dt_f, dt_u, dt_s, dt_deg} = dt_side;

    // group sequencer: a finished matrix waits here while the pipe keeps moving
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && matrix.ready)
        begin
            if (cnt_reg == lavm_pkg::LAST_GROUP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_s_reg   <= dt_s;
            m_u_reg   <= dt_u;
            m_f_reg   <= dt_f;
            m_t_reg   <= dt_trans;
            m_deg_reg <= dt_deg;
        end
    end

    assign matrix.valid = busy_reg;

    always_comb
    begin
        matrix.payload.group_index = cnt_reg;
        matrix.payload.degenerate  = m_deg_reg;
        priority if (cnt_reg == lavm_pkg::LAST_GROUP)
        begin
            matrix.payload.value_a    = m_t_reg[0];
            matrix.payload.value_b    = m_t_reg[1];
            matrix.payload.value_c    = m_t_reg[2];
            matrix.payload.value_d    = 32'(1) << F;
            matrix.payload.last_group = 1'b1;
        end
        else
        begin
            matrix.payload.value_a    = m_s_reg[cnt_reg];
            matrix.payload.value_b    = m_u_reg[cnt_reg];
            matrix.payload.value_c    = m_f_reg[cnt_reg];
            matrix.payload.value_d    = '0;
            matrix.payload.last_group = 1'b0;
        end
    end

endmodule

// File: hdl/lavm_checker.sv
// Port-level checks on the matrix channel, bound to the top level.
module lavm_checker #(
    parameter int FRACTION_BITS = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              mat_valid,
    input logic              mat_ready,
    input lavm_pkg::matrix_t mat_payload
);
    logic beat;
    assign beat = mat_valid && mat_ready;

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> mat_valid && $stable(mat_payload))
        else $error("matrix beat changed while stalled");

    // groups of one matrix follow back to back in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        beat && !mat_payload.last_group |=> mat_valid &&
        (mat_payload.group_index == 2'($past(mat_payload.group_index) + 2'd1)))
        else $error("matrix group out of order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |-> (mat_payload.last_group ==
        (mat_payload.group_index == lavm_pkg::LAST_GROUP)))
        else $error("last_group does not match group_index");

    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        beat && !mat_payload.last_group |=>
        mat_payload.degenerate == $past(mat_payload.degenerate))
        else $error("degenerate flag changed within one matrix");

    a_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |-> (mat_payload.value_d ==
        (mat_payload.last_group ? (32'(1) << FRACTION_BITS) : 32'(0))))
        else $error("fourth value of group is wrong");

endmodule

bind look_at_view_matrix_core lavm_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_lavm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .mat_valid   (matrix.valid),
    .mat_ready   (matrix.ready),
    .mat_payload (matrix.payload)
);
